@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/xst_pkg.sv @@
// ----------------------------------------------------------------------------
// Tokenizer package
// Request and result types, token kinds, characters and scan modes.
// ----------------------------------------------------------------------------
package xst_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
  } xst_in_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] char_out;
    logic       char_valid;
    logic       token_last;
    logic       parse_error;
    logic       run_last;
  } xst_res_t;

  typedef struct packed {
    logic [1:0] n;
    xst_res_t   r0;
    xst_res_t   r1;
  } xst_step_t;

  localparam logic [2:0] K_END   = 3'd0;
  localparam logic [2:0] K_OPEN  = 3'd1;
  localparam logic [2:0] K_CLOSE = 3'd2;
  localparam logic [2:0] K_GT    = 3'd3;
  localparam logic [2:0] K_EMPTY = 3'd4;
  localparam logic [2:0] K_NAME  = 3'd5;
  localparam logic [2:0] K_TEXT  = 3'd6;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] N_NONE = 2'd0;
  localparam logic [1:0] N_ONE  = 2'd1;
  localparam logic [1:0] N_TWO  = 2'd2;

  typedef enum logic [18:0] {
    M_OUT        = 19'd1 << 0,
    M_TEXT       = 19'd1 << 1,
    M_LT         = 19'd1 << 2,
    M_NAME_START = 19'd1 << 3,
    M_ELEM       = 19'd1 << 4,
    M_TAG        = 19'd1 << 5,
    M_ATTR       = 19'd1 << 6,
    M_EQ         = 19'd1 << 7,
    M_VALUE      = 19'd1 << 8,
    M_SLASH      = 19'd1 << 9,
    M_PI         = 19'd1 << 10,
    M_PI_QUOTE   = 19'd1 << 11,
    M_PI_Q       = 19'd1 << 12,
    M_BANG       = 19'd1 << 13,
    M_BANG2      = 19'd1 << 14,
    M_COMMENT    = 19'd1 << 15,
    M_COM_DASH   = 19'd1 << 16,
    M_COM_END    = 19'd1 << 17,
    M_DONE       = 19'd1 << 18
  } xst_mode_t;

  typedef enum logic [2:0] {
    R_START = 3'b001,
    R_TAG   = 3'b010,
    R_TEXT  = 3'b100
  } xst_resume_t;

  typedef struct packed {
    logic        emit;
    xst_res_t    res;
    xst_mode_t   mode;
    xst_resume_t resume;
    logic        err;
  } xst_sub_t;

endpackage

@@ hdl/xst_parser.sv @@
// ----------------------------------------------------------------------------
// Tokenizer parser
// Scan state and the single-pass step that turns one request into results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xst_parser import xst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  xst_in_t   item,
  output xst_step_t step
);

  xst_mode_t   mode_r, mode_nxt;
  xst_resume_t resume_r, resume_nxt;
  logic        err_r, err_nxt;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic xst_res_t mk(logic [2:0] k, logic [7:0] c, logic v, logic l, logic e);
    xst_res_t r;
    r.token_kind  = k;
    r.char_out    = c;
    r.char_valid  = v;
    r.token_last  = l;
    r.parse_error = e;
    r.run_last    = 1'b0;
    return r;
  endfunction

  function automatic xst_res_t err_res();
    return mk(K_END, 8'h00, 1'b0, 1'b0, 1'b1);
  endfunction

  function automatic xst_sub_t name_start(logic [7:0] c, xst_mode_t m, xst_resume_t rs);
    xst_sub_t s;
    s.emit   = 1'b1;
    s.mode   = m;
    s.resume = rs;
    if (is_alpha(c)) begin
      s.res  = mk(K_NAME, c, 1'b1, 1'b0, 1'b0);
      s.mode = M_ELEM;
      s.err  = 1'b0;
    end else begin
      s.res = err_res();
      s.err = 1'b1;
    end
    return s;
  endfunction

  function automatic xst_sub_t tag_interior(logic [7:0] c, xst_resume_t rs);
    xst_sub_t s;
    s.emit   = 1'b0;
    s.res    = err_res();
    s.mode   = M_TAG;
    s.resume = rs;
    s.err    = 1'b0;
    priority if (is_ws(c)) begin
      s.emit = 1'b0;
    end else if (c == CH_SLASH) begin
      s.mode = M_SLASH;
    end else if (c == CH_GT) begin
      s.emit   = 1'b1;
      s.res    = mk(K_GT, 8'h00, 1'b0, 1'b1, 1'b0);
      s.mode   = M_OUT;
      s.resume = R_TAG;
    end else if (is_alpha(c)) begin
      s.emit = 1'b1;
      s.res  = mk(K_NAME, c, 1'b1, 1'b0, 1'b0);
      s.mode = M_ATTR;
    end else begin
      s.emit = 1'b1;
      s.err  = 1'b1;
    end
    return s;
  endfunction

  always_comb begin
    logic [7:0] c;
    xst_sub_t   sub;
    c          = item.char_code;
    sub        = tag_interior(c, resume_r);
    mode_nxt   = mode_r;
    resume_nxt = resume_r;
    err_nxt    = err_r;
    step.n     = N_NONE;
    step.r0    = err_res();
    step.r1    = err_res();
    if (err_r) begin
      step.n = N_ONE;
    end else if (mode_r == M_DONE) begin
      step.n  = N_ONE;
      step.r0 = mk(K_END, 8'h00, 1'b0, 1'b1, 1'b0);
    end else if (item.req_type) begin
      if (mode_r == M_OUT) begin
        step.n   = N_ONE;
        step.r0  = mk(K_END, 8'h00, 1'b0, 1'b1, 1'b0);
        mode_nxt = M_DONE;
      end else if (mode_r == M_TEXT) begin
        step.n   = N_TWO;
        step.r0  = mk(K_TEXT, 8'h00, 1'b0, 1'b1, 1'b0);
        step.r1  = mk(K_END, 8'h00, 1'b0, 1'b1, 1'b0);
        mode_nxt = M_DONE;
      end else begin
        step.n  = N_ONE;
        err_nxt = 1'b1;
      end
    end else begin
      unique case (mode_r)
        M_OUT: begin
          if (!is_ws(c)) begin
            if (c == CH_LT) begin
              mode_nxt = M_LT;
            end else if (resume_r == R_TAG) begin
              step.n   = N_ONE;
              step.r0  = mk(K_TEXT, c, 1'b1, 1'b0, 1'b0);
              mode_nxt = M_TEXT;
            end else begin
              step.n  = N_ONE;
              err_nxt = 1'b1;
            end
          end
        end
        M_TEXT: begin
          step.n = N_ONE;
          if (c == CH_LT) begin
            step.r0    = mk(K_TEXT, 8'h00, 1'b0, 1'b1, 1'b0);
            mode_nxt   = M_LT;
            resume_nxt = R_TEXT;
          end else begin
            step.r0 = mk(K_TEXT, c, 1'b1, 1'b0, 1'b0);
          end
        end
        M_LT: begin
          if (!is_ws(c)) begin
            priority if (c == CH_SLASH) begin
              step.n   = N_ONE;
              step.r0  = mk(K_CLOSE, 8'h00, 1'b0, 1'b1, 1'b0);
              mode_nxt = M_NAME_START;
            end else if (c == CH_QMARK) begin
              mode_nxt = M_PI;
            end else if (c == CH_BANG) begin
              mode_nxt = M_BANG;
            end else begin
              sub      = name_start(c, mode_r, resume_r);
              step.n   = N_TWO;
              step.r0  = mk(K_OPEN, 8'h00, 1'b0, 1'b1, 1'b0);
              step.r1  = sub.res;
              mode_nxt = sub.mode;
              err_nxt  = sub.err;
            end
          end
        end
        M_NAME_START: begin
          if (!is_ws(c)) begin
            sub      = name_start(c, mode_r, resume_r);
            step.n   = N_ONE;
            step.r0  = sub.res;
            mode_nxt = sub.mode;
            err_nxt  = sub.err;
          end
        end
        M_ELEM: begin
          if (is_alpha(c)) begin
            step.n  = N_ONE;
            step.r0 = mk(K_NAME, c, 1'b1, 1'b0, 1'b0);
          end else begin
            step.r0 = mk(K_NAME, 8'h00, 1'b0, 1'b1, 1'b0);
            if (c == CH_EQ) begin
              step.n  = N_TWO;
              err_nxt = 1'b1;
            end else begin
              step.n     = sub.emit ? N_TWO : N_ONE;
              step.r1    = sub.res;
              mode_nxt   = sub.mode;
              resume_nxt = sub.resume;
              err_nxt    = sub.err;
            end
          end
        end
        M_TAG: begin
          step.n     = sub.emit ? N_ONE : N_NONE;
          step.r0    = sub.res;
          mode_nxt   = sub.mode;
          resume_nxt = sub.resume;
          err_nxt    = sub.err;
        end
        M_ATTR: begin
          step.n = N_ONE;
          if (is_alpha(c)) begin
            step.r0 = mk(K_NAME, c, 1'b1, 1'b0, 1'b0);
          end else if (c == CH_EQ) begin
            step.r0  = mk(K_NAME, 8'h00, 1'b0, 1'b1, 1'b0);
            mode_nxt = M_EQ;
          end else begin
            err_nxt = 1'b1;
          end
        end
        M_EQ: begin
          if (!is_ws(c)) begin
            if (c == CH_QUOTE) begin
              mode_nxt = M_VALUE;
            end else begin
              step.n  = N_ONE;
              err_nxt = 1'b1;
            end
          end
        end
        M_VALUE: begin
          step.n = N_ONE;
          if (c == CH_QUOTE) begin
            step.r0  = mk(K_TEXT, 8'h00, 1'b0, 1'b1, 1'b0);
            mode_nxt = M_TAG;
          end else begin
            step.r0 = mk(K_TEXT, c, 1'b1, 1'b0, 1'b0);
          end
        end
        M_SLASH: begin
          if (!is_ws(c)) begin
            step.n = N_ONE;
            if (c == CH_GT) begin
              step.r0    = mk(K_EMPTY, 8'h00, 1'b0, 1'b1, 1'b0);
              mode_nxt   = M_OUT;
              resume_nxt = R_TAG;
            end else begin
              err_nxt = 1'b1;
            end
          end
        end
        M_PI: begin
          if (c == CH_QUOTE) begin
            mode_nxt = M_PI_QUOTE;
          end else if (c == CH_QMARK) begin
            mode_nxt = M_PI_Q;
          end
        end
        M_PI_QUOTE: begin
          if (c == CH_QUOTE) begin
            mode_nxt = M_PI;
          end
        end
        M_PI_Q, M_COM_END: begin
          if (c == CH_GT) begin
            mode_nxt = M_OUT;
          end else begin
            step.n  = N_ONE;
            err_nxt = 1'b1;
          end
        end
        M_BANG: begin
          if (c == CH_DASH) begin
            mode_nxt = M_BANG2;
          end else begin
            step.n  = N_ONE;
            err_nxt = 1'b1;
          end
        end
        M_BANG2: begin
          if (c == CH_DASH) begin
            mode_nxt = M_COMMENT;
          end else begin
            step.n  = N_ONE;
            err_nxt = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == CH_DASH) begin
            mode_nxt = M_COM_DASH;
          end
        end
        M_COM_DASH: begin
          mode_nxt = (c == CH_DASH) ? M_COM_END : M_COMMENT;
        end
        default: begin
          step.n  = N_ONE;
          err_nxt = 1'b1;
        end
      endcase
    end
    if (step.n == N_ONE) begin
      step.r0.run_last = 1'b1;
    end else if (step.n == N_TWO) begin
      step.r1.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_OUT;
      resume_r <= R_START;
      err_r    <= 1'b0;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      resume_r <= resume_nxt;
      err_r    <= err_nxt;
    end
  end

  `ASSERT_NEXT(a_err_sticky, clk, rst_n, err_r, err_r)
  `ASSERT_IMPLIES(a_two_run_last, clk, rst_n, step.n == N_TWO,
                  !step.r0.run_last && step.r1.run_last)

endmodule

@@ hdl/xst_res_fifo.sv @@
// ----------------------------------------------------------------------------
// Result queue
// Four-entry queue that takes up to two results a cycle while it has room and gives one while the receiver is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xst_res_fifo import xst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_en,
  input  xst_step_t push,
  output logic      has_room,
  output logic      out_valid,
  input  logic      out_ready,
  output xst_res_t  out_data
);

  xst_res_t   mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] push_n;
  logic       pop;

  assign push_n    = push_en ? push.n : N_NONE;
  assign pop       = out_valid && out_ready;
  assign has_room  = count_r <= 3'd2;
  assign out_valid = count_r != 3'd0;
  assign out_data  = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + push_n;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign count_nxt  = count_r + {1'b0, push_n} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push_n != N_NONE) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push_n == N_TWO) begin
      mem_r[wr_ptr_r + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push_n != N_NONE, has_room)

endmodule

@@ hdl/xml_subset_tokenizer.sv @@
// Flow: an accepted request waits in the input register until the result queue has room;
// it is then parsed combinationally, its results enter the queue, which offers them
// on the output in order. Throughput: one request a cycle while the four-entry result queue
// has room; the input stalls only while the queue holds three results or more.
// Reset: synchronous, active low; clears the input valid flag, scan state, error flag and queue.
// ----------------------------------------------------------------------------
// XML subset tokenizer
// Input register, single-pass parser step and result queue.
// ----------------------------------------------------------------------------
module xml_subset_tokenizer import xst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  xst_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output xst_res_t out_data
);

  logic      in_vld_r, in_vld_nxt;
  xst_in_t   in_data_r;
  logic      has_room;
  logic      advance;
  xst_step_t step;

  assign advance    = in_vld_r && has_room;
  assign in_ready   = !in_vld_r || advance;
  assign in_vld_nxt = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : in_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  xst_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_data_r),
    .step    (step)
  );

  xst_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (advance),
    .push      (step),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
